FILE: rtl/core/assert_macros.svh
// Assertion shorthands shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define TCLA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An event that must be followed by a condition in the next cycle.
`define TCLA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tcla_pkg.sv
package tcla_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam logic [31:0] WINDOW_RESET = 32'd100000;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [2:0] KIND_STATUS    = 3'd0;
  localparam logic [2:0] KIND_SEGMENT   = 3'd1;
  localparam logic [2:0] KIND_LEVEL     = 3'd2;
  localparam logic [2:0] KIND_NO_DATA   = 3'd3;
  localparam logic [2:0] KIND_ENTRY     = 3'd4;
  localparam logic [2:0] KIND_BAD_INDEX = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  pins;
    logic [31:0] time_us;
    logic [5:0]  channel_mask;
    logic [5:0]  entry_index;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        level;
    logic [31:0] duration_us;
    logic [5:0]  pins_out;
    logic [31:0] time_out;
    logic [5:0]  count;
    logic        capturing;
    logic        stored;
    logic        last;
  } result_t;

  // One stored capture entry.
  typedef struct packed {
    logic [5:0]  pins;
    logic [31:0] stamp;
  } entry_t;

endpackage

FILE: rtl/core/tcla_store.sv
module tcla_store #(
  parameter int DEPTH = tcla_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  tcla_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output tcla_pkg::entry_t rdata
);
  import tcla_pkg::*;

  entry_t mem [DEPTH];

  // Single write port, single read port, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/transition_capture_logic_analyzer.sv
// Channel   Signals                         Direction  Transfer
// command   start, item                     in         start && !busy
// result    valid, result                   out        every cycle valid is high
// config    window_we, window_data          in         window_we high
//
// Start and sample commands leave busy low and may follow each other in
// consecutive cycles; a read holds busy in the read state while the entry store
// delivers its registered read data; a channel report holds busy through the walk
// state, one store read per cycle, and the flush state that closes the walk.
// Reset is synchronous and clears only control state; the store contents are
// not cleared, since no entry is read before it has been written.
// Results cannot be stalled: each is on the result port for exactly one cycle.
`include "assert_macros.svh"

module transition_capture_logic_analyzer #(
  parameter int DEPTH = tcla_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tcla_pkg::item_t   item,
  output logic              busy,
  input  logic              window_we,
  input  logic [31:0]       window_data,
  output logic              valid,
  output tcla_pkg::result_t result
);
  import tcla_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] FULL = AW'(DEPTH - 1);

  // The sequencer: idle takes commands, read waits out the store latency,
  // walk streams the store for a report and flush emits its final result.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t      state, state_next;
  logic [31:0] window_us;
  logic [AW-1:0] entry_count, count_next;
  logic        capture_open, open_next;
  logic [31:0] start_time, start_next;
  // Copy of the pins of the last stored entry, so a sample needs no store read.
  logic [5:0]  last_pins;

  logic        res_valid_next;
  result_t     res_next;

  // Store ports.
  logic        we, re;
  logic [AW-1:0] raddr;
  entry_t      wdata, rdata;

  // Report walk.
  logic [AW:0] iss_addr, iss_next;
  logic        dv, dv_next;
  logic [AW-1:0] di;
  logic [5:0]  mask;
  logic [5:0]  ref_m;
  logic [31:0] ref_t;
  logic        lvl0;
  logic        pend_valid;
  logic        pend_level;
  logic [31:0] pend_dur;

  logic        accept;
  logic        rpt_start;
  logic        walk_rd;
  logic [5:0]  cur_m;
  logic        seg_hit;
  logic        walk_end;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign wdata   = '{pins: item.pins, stamp: item.time_us};
  assign cur_m   = rdata.pins & mask;
  // A segment ends wherever the masked levels differ from the reference entry.
  assign seg_hit  = (state == ST_WALK) && dv && (di != '0) && (cur_m != ref_m);
  assign walk_end = (state == ST_WALK) && dv && (di == entry_count - AW'(1));

  tcla_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (entry_count),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    count_next     = entry_count;
    open_next      = capture_open;
    start_next     = start_time;
    res_valid_next = 1'b0;
    res_next       = '0;
    we             = 1'b0;
    re             = 1'b0;
    raddr          = iss_addr[AW-1:0];
    iss_next       = iss_addr;
    rpt_start      = 1'b0;
    walk_rd        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.command)
            CMD_START: begin
              count_next     = '0;
              open_next      = 1'b1;
              start_next     = item.time_us;
              res_valid_next = 1'b1;
              res_next.kind  = KIND_STATUS;
              res_next.last  = 1'b1;
            end
            CMD_SAMPLE: begin
              if (capture_open) begin
                if ((item.time_us - start_time) >= window_us) begin
                  open_next = 1'b0;
                end else if (entry_count < FULL) begin
                  if ((entry_count == '0) || (last_pins != item.pins)) begin
                    we              = 1'b1;
                    count_next      = entry_count + AW'(1);
                    res_next.stored = 1'b1;
                  end
                  if (count_next >= FULL) begin
                    open_next = 1'b0;
                  end
                end else begin
                  open_next = 1'b0;
                end
              end
              res_valid_next = 1'b1;
              res_next.kind  = KIND_STATUS;
              res_next.last  = 1'b1;
            end
            CMD_REPORT: begin
              if (entry_count == '0) begin
                res_valid_next = 1'b1;
                res_next.kind  = KIND_NO_DATA;
                res_next.last  = 1'b1;
              end else begin
                re         = 1'b1;
                raddr      = '0;
                walk_rd    = 1'b1;
                rpt_start  = 1'b1;
                iss_next   = (AW+1)'(1);
                state_next = ST_WALK;
              end
            end
            CMD_READ: begin
              if (item.entry_index < 6'(entry_count)) begin
                re         = 1'b1;
                raddr      = item.entry_index[AW-1:0];
                state_next = ST_READ;
              end else begin
                res_valid_next = 1'b1;
                res_next.kind  = KIND_BAD_INDEX;
                res_next.last  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_valid_next    = 1'b1;
        res_next.kind     = KIND_ENTRY;
        res_next.pins_out = rdata.pins;
        res_next.time_out = rdata.stamp;
        res_next.last     = 1'b1;
        state_next        = ST_IDLE;
      end
      ST_WALK: begin
        if (iss_addr < {1'b0, entry_count}) begin
          re       = 1'b1;
          walk_rd  = 1'b1;
          iss_next = iss_addr + (AW+1)'(1);
        end
        // A new segment pushes out the one held back, which is not the last.
        if (seg_hit && pend_valid) begin
          res_valid_next       = 1'b1;
          res_next.kind        = KIND_SEGMENT;
          res_next.level       = pend_level;
          res_next.duration_us = pend_dur;
        end
        if (walk_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        res_valid_next = 1'b1;
        res_next.last  = 1'b1;
        if (pend_valid) begin
          res_next.kind        = KIND_SEGMENT;
          res_next.level       = pend_level;
          res_next.duration_us = pend_dur;
        end else begin
          res_next.kind  = KIND_LEVEL;
          res_next.level = lvl0;
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    res_next.count     = 6'(count_next);
    res_next.capturing = open_next;
    dv_next            = walk_rd;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_us    <= WINDOW_RESET;
      entry_count  <= '0;
      capture_open <= 1'b0;
      start_time   <= '0;
      valid        <= 1'b0;
      dv           <= 1'b0;
      pend_valid   <= 1'b0;
      iss_addr     <= '0;
    end else begin
      state        <= state_next;
      entry_count  <= count_next;
      capture_open <= open_next;
      start_time   <= start_next;
      valid        <= res_valid_next;
      dv           <= dv_next;
      iss_addr     <= iss_next;
      if (window_we) begin
        window_us <= window_data;
      end
      if (rpt_start) begin
        pend_valid <= 1'b0;
      end else if (seg_hit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    result <= res_next;
    if (we) begin
      last_pins <= item.pins;
    end
    if (walk_rd) begin
      di <= raddr;
    end
    if (rpt_start) begin
      mask <= item.channel_mask;
    end
    if ((state == ST_WALK) && dv) begin
      if (di == '0) begin
        ref_m <= cur_m;
        ref_t <= rdata.stamp;
        lvl0  <= |cur_m;
      end else if (seg_hit) begin
        ref_m      <= cur_m;
        ref_t      <= rdata.stamp;
        pend_level <= |ref_m;
        pend_dur   <= rdata.stamp - ref_t;
      end
    end
  end

  `TCLA_ASSERT(a_count_bound, clk, rst, entry_count <= FULL,
    "entry count passed the store limit")
  `TCLA_ASSERT(a_last_idle, clk, rst, !(valid && result.last) || (state == ST_IDLE),
    "final result delivered while the sequencer is not idle")
  `TCLA_ASSERT_NEXT(a_start_arms, clk, rst, accept && (item.command == CMD_START),
    valid && capture_open && (entry_count == '0),
    "start transfer did not arm an empty capture")
  `TCLA_ASSERT(a_mid_walk, clk, rst,
    !(valid && !result.last) || (state == ST_WALK) || (state == ST_FLUSH),
    "non-final result outside a report walk")

endmodule

FILE: bench/tb_transition_capture_logic_analyzer.sv
module tb_transition_capture_logic_analyzer;
  import tcla_pkg::*;

  // Store depth used for the instance; the shadow store below matches it.
  localparam int SLOTS = DEPTH_DEFAULT;

  // Hard stop for a hung or silent block. The slowest correct run is far below this:
  // about 450 transfers, six reports that walk a full store with busy high throughout,
  // and a 6 percent chance of an idle cycle per transfer.
  localparam int CYCLE_LIMIT = 400000;

  // Idle cycles after the last result before the block counts as drained. A report of a
  // full store keeps busy high through its whole walk, so the final drain waits longer.
  localparam int SETTLE_SHORT = 4;
  localparam int SETTLE_FINAL = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  item_t       item = '0;
  logic        busy;
  logic        window_we = 1'b0;
  logic [31:0] window_data = '0;
  logic        valid;
  result_t     result;

  transition_capture_logic_analyzer #(.DEPTH(SLOTS)) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .busy        (busy),
    .window_we   (window_we),
    .window_data (window_data),
    .valid       (valid),
    .result      (result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Commands waiting to be offered to the block, and the results that the accepted
  // commands are known to owe, oldest first.
  item_t   cmd_backlog[$];
  result_t awaited_results[$];

  // Shadow copy of the analyzer: capture store, fill level, window state and the
  // window length register. Store contents start unknown, but no entry beyond the
  // fill level is ever looked at, so that value never shows up in a result.
  logic [5:0]  shadow_pins [SLOTS];
  logic [31:0] shadow_stamp [SLOTS];
  int          shadow_count = 0;
  bit          shadow_open = 1'b0;
  logic [31:0] shadow_origin = '0;
  logic [31:0] shadow_window = WINDOW_RESET;

  bit  took = 1'b0;      // a transfer happened at the last rising edge
  bit  gaps_on = 1'b1;   // random idle cycles on the command side
  int  quiet = 0;        // consecutive cycles with nothing in flight
  int  cycles = 0;
  int  tb_errors = 0;

  // A result word as the block reports it after the current command, with the fill
  // level and window state taken from the shadow copy.
  function automatic result_t make_result(input logic [2:0] kind, input logic level,
                                          input logic [31:0] span_us,
                                          input logic [5:0] lines,
                                          input logic [31:0] stamp, input logic wrote);
    result_t r;
    r.kind        = kind;
    r.level       = level;
    r.duration_us = span_us;
    r.pins_out    = lines;
    r.time_out    = stamp;
    r.count       = 6'(shadow_count);
    r.capturing   = shadow_open;
    r.stored      = wrote;
    r.last        = 1'b0;
    return r;
  endfunction

  // Advances the shadow analyzer by one accepted command and appends the results that
  // command owes to the awaited list, flagging the final one.
  task automatic predict_transfer(input item_t it);
    result_t     owed[$];
    result_t     r;
    logic [31:0] elapsed;
    logic [5:0]  lane_now;
    logic [5:0]  lane_was;
    int          seg_from;
    int          i;
    bit          wrote;
    wrote = 1'b0;
    case (it.command)
      CMD_START: begin
        // A start always empties the store and reopens the window, even mid-capture.
        shadow_count  = 0;
        shadow_open   = 1'b1;
        shadow_origin = it.time_us;
        owed.push_back(make_result(KIND_STATUS, 1'b0, '0, '0, '0, 1'b0));
      end
      CMD_SAMPLE: begin
        if (shadow_open) begin
          // The window test uses wrapped time, so a capture may span the rollover.
          elapsed = it.time_us - shadow_origin;
          if (elapsed >= shadow_window) begin
            shadow_open = 1'b0;
          end else if (shadow_count < SLOTS - 1) begin
            // Only the first sample and changes of the pin levels are kept.
            if (shadow_count == 0 || shadow_pins[shadow_count - 1] != it.pins) begin
              shadow_pins[shadow_count]  = it.pins;
              shadow_stamp[shadow_count] = it.time_us;
              shadow_count = shadow_count + 1;
              wrote = 1'b1;
            end
            if (shadow_count >= SLOTS - 1) shadow_open = 1'b0;
          end else begin
            shadow_open = 1'b0;
          end
        end
        owed.push_back(make_result(KIND_STATUS, 1'b0, '0, '0, '0, wrote));
      end
      CMD_REPORT: begin
        if (shadow_count == 0) begin
          owed.push_back(make_result(KIND_NO_DATA, 1'b0, '0, '0, '0, 1'b0));
        end else begin
          // Each masked change closes the segment that began at the previous change.
          seg_from = 0;
          for (i = 1; i < shadow_count; i++) begin
            lane_now = shadow_pins[i] & it.channel_mask;
            lane_was = shadow_pins[seg_from] & it.channel_mask;
            if (lane_now != lane_was) begin
              owed.push_back(make_result(KIND_SEGMENT, |lane_was,
                                         shadow_stamp[i] - shadow_stamp[seg_from],
                                         '0, '0, 1'b0));
              seg_from = i;
            end
          end
          if (owed.size() == 0) begin
            owed.push_back(make_result(KIND_LEVEL, |(shadow_pins[0] & it.channel_mask),
                                       '0, '0, '0, 1'b0));
          end
        end
      end
      default: begin
        if (it.entry_index < shadow_count) begin
          owed.push_back(make_result(KIND_ENTRY, 1'b0, '0, shadow_pins[it.entry_index],
                                     shadow_stamp[it.entry_index], 1'b0));
        end else begin
          owed.push_back(make_result(KIND_BAD_INDEX, 1'b0, '0, '0, '0, 1'b0));
        end
      end
    endcase
    r = owed.pop_back();
    r.last = 1'b1;
    owed.push_back(r);
    while (owed.size() != 0) awaited_results.push_back(owed.pop_front());
  endtask

  function automatic string show(input result_t r);
    return $sformatf("kind=%0d level=%0d dur=%h pins=%h time=%h count=%0d cap=%0d st=%0d last=%0d",
                     r.kind, r.level, r.duration_us, r.pins_out, r.time_out, r.count,
                     r.capturing, r.stored, r.last);
  endfunction

  task automatic check_result(input result_t got);
    result_t exp;
    string   diffs;
    diffs = "";
    if (awaited_results.size() == 0) begin
      tb_errors = tb_errors + 1;
      if (tb_errors <= 10) $display("unexpected result: %s", show(got));
    end else begin
      exp = awaited_results.pop_front();
      if (got.kind !== exp.kind) diffs = {diffs, " kind"};
      if (got.level !== exp.level) diffs = {diffs, " level"};
      if (got.duration_us !== exp.duration_us) diffs = {diffs, " duration_us"};
      if (got.pins_out !== exp.pins_out) diffs = {diffs, " pins_out"};
      if (got.time_out !== exp.time_out) diffs = {diffs, " time_out"};
      if (got.count !== exp.count) diffs = {diffs, " count"};
      if (got.capturing !== exp.capturing) diffs = {diffs, " capturing"};
      if (got.stored !== exp.stored) diffs = {diffs, " stored"};
      if (got.last !== exp.last) diffs = {diffs, " last"};
      if (diffs != "") begin
        tb_errors = tb_errors + 1;
        if (tb_errors <= 10) begin
          $display("result mismatch in%s", diffs);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(got));
        end
      end
    end
  endtask

  // Command driver. Inputs move on the falling edge. A command stays on the port until
  // a transfer takes it; then the next one follows at once unless a random idle cycle
  // is drawn.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (cmd_backlog.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 6)) begin
        item  <= cmd_backlog.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. At each rising edge, a transfer is predicted before the result port is
  // checked, so a result that could appear in the same cycle still finds its
  // expectation waiting.
  always @(posedge clk) begin
    took <= !rst && start && !busy;
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) predict_transfer(item);
      if (valid) check_result(result);
    end
    if (rst || start || busy || valid || awaited_results.size() != 0 ||
        cmd_backlog.size() != 0) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_op(input logic [1:0] op, input logic [5:0] lines,
                          input logic [31:0] stamp, input logic [5:0] mask,
                          input logic [5:0] slot);
    item_t it;
    it.command      = op;
    it.pins         = lines;
    it.time_us      = stamp;
    it.channel_mask = mask;
    it.entry_index  = slot;
    cmd_backlog.push_back(it);
  endtask

  // Waits until every queued command has been taken, every owed result has come and
  // the block has sat idle for the given number of cycles.
  task automatic settle(input int hold);
    do @(negedge clk); while (cmd_backlog.size() != 0 || quiet < hold);
  endtask

  // The window register is only written while the block is drained.
  task automatic set_window(input logic [31:0] len);
    @(negedge clk);
    window_we     <= 1'b1;
    window_data   <= len;
    shadow_window = len;
    @(negedge clk);
    window_we <= 1'b0;
  endtask

  // Time between samples: mostly short, now and then long enough to close a window.
  function automatic logic [31:0] gap_us();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, 1500);
    if (roll < 95) return $urandom_range(0, 200000);
    return $urandom();
  endfunction

  // Reports mostly look at one line, as in normal use, and sometimes at a random group.
  function automatic logic [5:0] pick_mask();
    if ($urandom_range(0, 1) != 0) return 6'd1 << $urandom_range(0, 5);
    return 6'($urandom());
  endfunction

  initial begin : stimulus
    logic [31:0] clock_us;
    logic [31:0] len;
    logic [5:0]  held;
    int          round;
    int          made;
    int          span;
    int          roll;
    int          k;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the reset window of 100000 us. Nothing is stored yet, and a
    // sample before any start is ignored.
    queue_op(CMD_REPORT, 6'h00, 32'd0, 6'h3f, 6'd0);
    queue_op(CMD_READ,   6'h00, 32'd0, 6'h00, 6'd0);
    queue_op(CMD_SAMPLE, 6'h15, 32'd5, 6'h00, 6'd0);
    // A capture that starts just before the timestamp rolls over. The first sample is
    // stored even with all lines low; a repeat of the same levels is not.
    queue_op(CMD_START,  6'h00, 32'hffff_fff0, 6'h00, 6'd0);
    queue_op(CMD_SAMPLE, 6'h00, 32'hffff_fff0, 6'h00, 6'd0);
    queue_op(CMD_SAMPLE, 6'h00, 32'hffff_fff5, 6'h00, 6'd0);
    queue_op(CMD_SAMPLE, 6'h3f, 32'h0000_0005, 6'h00, 6'd0);
    queue_op(CMD_SAMPLE, 6'h2a, 32'h0000_0100, 6'h00, 6'd0);
    queue_op(CMD_SAMPLE, 6'h15, 32'h0000_0200, 6'h00, 6'd0);
    // Reports while capturing: all lines, a zero mask (level only) and one line.
    queue_op(CMD_REPORT, 6'h00, 32'd0, 6'h3f, 6'd0);
    queue_op(CMD_REPORT, 6'h00, 32'd0, 6'h00, 6'd0);
    queue_op(CMD_REPORT, 6'h00, 32'd0, 6'h01, 6'd0);
    // Reads of the first and last entries, one past the end and the top index.
    queue_op(CMD_READ,   6'h00, 32'd0, 6'h00, 6'd0);
    queue_op(CMD_READ,   6'h00, 32'd0, 6'h00, 6'd3);
    queue_op(CMD_READ,   6'h00, 32'd0, 6'h00, 6'd4);
    queue_op(CMD_READ,   6'h00, 32'd0, 6'h00, 6'd63);
    // Elapsed time equal to the window closes the capture; later samples are ignored.
    queue_op(CMD_SAMPLE, 6'h00, 32'h0001_8690, 6'h00, 6'd0);
    queue_op(CMD_SAMPLE, 6'h3f, 32'h0001_8691, 6'h00, 6'd0);
    queue_op(CMD_REPORT, 6'h00, 32'd0, 6'h20, 6'd0);
    // A start while capturing restarts the capture and empties the store.
    queue_op(CMD_START,  6'h00, 32'd1000, 6'h00, 6'd0);
    queue_op(CMD_START,  6'h00, 32'd2000, 6'h00, 6'd0);
    queue_op(CMD_REPORT, 6'h00, 32'd0, 6'h3f, 6'd0);
    queue_op(CMD_SAMPLE, 6'h07, 32'd2000, 6'h00, 6'd0);
    // A single entry can only give its level.
    queue_op(CMD_REPORT, 6'h00, 32'd0, 6'h01, 6'd0);
    settle(SETTLE_SHORT);

    // A zero window closes at the very first sample.
    set_window(32'd0);
    queue_op(CMD_START,  6'h00, 32'h1234_5678, 6'h00, 6'd0);
    queue_op(CMD_SAMPLE, 6'h2a, 32'h1234_5678, 6'h00, 6'd0);
    queue_op(CMD_REPORT, 6'h00, 32'd0, 6'h3f, 6'd0);
    settle(SETTLE_SHORT);

    // Random part, in rounds. Each round writes a new window length, opens a capture at
    // a random time and then feeds mostly in-order samples mixed with reports, reads,
    // restarts and stray samples at random times. Every fifth round fills the store
    // to its limit with line 1 toggling on each sample, which gives a report with the
    // most segments possible. The directed part above already sent 27 commands.
    made  = 27;
    round = 0;
    while (made < 410) begin
      case (round)
        0, 5:    len = 32'hffff_ffff;
        1:       len = 32'd1;
        2:       len = $urandom();
        3:       len = 32'd100000;
        4:       len = $urandom_range(1, 5000);
        6:       len = 32'd0;
        default: len = $urandom_range(2000, 400000);
      endcase
      // Two rounds run with no idle cycles at all, to keep commands back to back.
      gaps_on = !(round == 3 || round == 4);
      set_window(len);
      clock_us = $urandom();
      held     = 6'($urandom());
      queue_op(CMD_START, 6'($urandom()), clock_us, 6'($urandom()), 6'($urandom()));
      if (round % 5 == 0) begin
        for (k = 0; k < 70; k++) begin
          clock_us = clock_us + $urandom_range(1, 900);
          held     = {5'($urandom()), ~held[0]};
          queue_op(CMD_SAMPLE, held, clock_us, 6'($urandom()), 6'($urandom()));
        end
        queue_op(CMD_REPORT, 6'($urandom()), 32'($urandom()), 6'h01, 6'($urandom()));
        queue_op(CMD_REPORT, 6'($urandom()), 32'($urandom()), 6'h3f, 6'($urandom()));
        queue_op(CMD_REPORT, 6'($urandom()), 32'($urandom()), pick_mask(), 6'd0);
        queue_op(CMD_READ, 6'($urandom()), 32'($urandom()), 6'($urandom()), 6'd0);
        queue_op(CMD_READ, 6'($urandom()), 32'($urandom()), 6'($urandom()), 6'd62);
        queue_op(CMD_READ, 6'($urandom()), 32'($urandom()), 6'($urandom()), 6'd63);
        made = made + 77;
      end else begin
        span = $urandom_range(30, 50);
        for (k = 0; k < span; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 65) begin
            clock_us = clock_us + gap_us();
            if ($urandom_range(0, 3) != 0) held = 6'($urandom());
            queue_op(CMD_SAMPLE, held, clock_us, 6'($urandom()), 6'($urandom()));
          end else if (roll < 77) begin
            queue_op(CMD_REPORT, 6'($urandom()), 32'($urandom()), pick_mask(),
                     6'($urandom()));
          end else if (roll < 89) begin
            queue_op(CMD_READ, 6'($urandom()), 32'($urandom()), 6'($urandom()),
                     ($urandom_range(0, 1) != 0) ? 6'($urandom()) : 6'($urandom_range(0, 12)));
          end else if (roll < 94) begin
            clock_us = clock_us + gap_us();
            queue_op(CMD_START, 6'($urandom()), clock_us, 6'($urandom()), 6'($urandom()));
          end else begin
            // A stray sample out of time order, which mostly closes the window.
            queue_op(CMD_SAMPLE, 6'($urandom()), 32'($urandom()), 6'($urandom()),
                     6'($urandom()));
          end
        end
        made = made + span + 1;
      end
      settle(SETTLE_SHORT);
      round = round + 1;
    end

    settle(SETTLE_FINAL);
    if (tb_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
